### design/npca_pkg.sv
// npca_pkg: types, codes and helpers shared by the node pool chain allocator
// used by npca_link_ram, node_pool_chain_allocator and its checker
package npca_pkg;

   localparam int POOL_NODES = 512;
   localparam int ADDR_W     = $clog2(POOL_NODES);
   localparam int NODE_W     = 10;
   localparam logic [NODE_W-1:0] NULL_NODE = NODE_W'(POOL_NODES);
   localparam logic [7:0] NO_PARENT_BYTE = 8'hff;

   typedef enum logic [2:0] {
      FUNC_GET_START = 3'd0,
      FUNC_GET_NODE  = 3'd1,
      FUNC_FREE      = 3'd2,
      FUNC_SUB       = 3'd3,
      FUNC_ADD       = 3'd4,
      FUNC_INIT      = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_REFUSED = 2'd1,
      STAT_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PWALK,
      ST_CREAD,
      ST_FWALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [9:0]  count;
      logic [7:0]  hier_byte;
      logic [9:0]  chain_head;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [9:0]         node_index;
      logic [9:0]         parent_index;
      logic [9:0]         freed_count;
      logic signed [15:0] rest;
      logic               last_of_run;
   } rsp_type;

   // link memory access bundle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [NODE_W-1:0] wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctl_type;

   // clamp a widened sum into the signed 16-bit counter range
   function automatic logic signed [15:0] sat16(logic signed [16:0] v);
      logic signed [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic node_valid(logic [NODE_W-1:0] n);
      return n < NULL_NODE;
   endfunction

endpackage

### design/npca_link_ram.sv
// npca_link_ram: link memory of the node pool, one write and one read port
// registered read data; depends on npca_pkg
module npca_link_ram (
   input  logic                          clock,
   input  npca_pkg::ram_ctl_type         ctl,
   output logic [npca_pkg::NODE_W-1:0]   rd_data
);

   logic [npca_pkg::NODE_W-1:0] mem [npca_pkg::POOL_NODES];

   // write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data <= mem[ctl.rd_addr];
   end

endmodule

### design/node_pool_chain_allocator.sv
// node pool chain allocator: one result word per request word
// get start, add, subtract, refused and ignored words go from idle straight to done;
// get node steps parent links in pwalk, then reads the cursor in cread; free walks a valid chain in fwalk
// init runs the clearing pass, one link memory write a cycle, before its result
// reset: synchronous; a clearing pass rewrites the link memory, req_stall held high
// one word in work at a time; the next word is taken while a result waits in rsp_word
module node_pool_chain_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  npca_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output npca_pkg::rsp_type rsp_word,
   output logic              csr_unused
);

   localparam int AW = npca_pkg::ADDR_W;
   localparam int NW = npca_pkg::NODE_W;

   npca_pkg::state_type   state_ff, state_in;
   logic [NW-1:0]         free_head_ff, free_head_in;
   logic signed [15:0]    avail_ff, avail_in;
   logic [9:0]            run_rem_ff, run_rem_in;
   logic [NW-1:0]         run_first_ff, run_first_in;
   logic [NW-1:0]         run_cursor_ff, run_cursor_in;
   logic [NW-1:0]         run_prev_ff, run_prev_in;
   logic [NW-1:0]         walk_ptr_ff, walk_ptr_in;
   logic [9:0]            walk_cnt_ff, walk_cnt_in;
   logic [NW-1:0]         chain_head_ff, chain_head_in;
   logic [AW-1:0]         clr_idx_ff, clr_idx_in;
   logic                  clr_init_ff, clr_init_in;
   npca_pkg::rsp_type     res_ff, res_in;
   npca_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   npca_pkg::ram_ctl_type ram_ctl;
   logic [NW-1:0]         rd_data;

   logic                  accept;
   logic                  in_run;
   logic                  load_rsp;
   logic signed [16:0]    avail_wide;
   logic signed [16:0]    cnt_wide;
   logic [9:0]            rem_dec;
   logic [9:0]            walk_dec;
   logic [NW-1:0]         cur_next;
   logic [NW-1:0]         prev_next;

   npca_link_ram u_link_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != npca_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign in_run     = (run_rem_ff != 10'd0);
   assign load_rsp   = (state_ff == npca_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign avail_wide = {avail_ff[15], avail_ff};
   assign cnt_wide   = $signed({7'd0, req_word.count});
   assign rem_dec    = run_rem_ff - 10'd1;
   assign walk_dec   = walk_cnt_ff - 10'd1;
   assign csr_unused = 1'b0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npca_pkg::ST_CLEAR: begin
            if (clr_idx_ff == AW'(npca_pkg::POOL_NODES - 1)) begin
               state_in = clr_init_ff ? npca_pkg::ST_DONE : npca_pkg::ST_IDLE;
            end
         end
         npca_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = npca_pkg::ST_DONE;
               if (req_word.func == npca_pkg::FUNC_INIT) begin
                  state_in = npca_pkg::ST_CLEAR;
               end else if (req_word.func == npca_pkg::FUNC_GET_NODE) begin
                  if (in_run) begin
                     if (req_word.hier_byte != npca_pkg::NO_PARENT_BYTE &&
                         req_word.hier_byte != 8'd0 &&
                         npca_pkg::node_valid(run_first_ff)) begin
                        state_in = npca_pkg::ST_PWALK;
                     end else begin
                        state_in = npca_pkg::ST_CREAD;
                     end
                  end
               end else if (!in_run && req_word.func == npca_pkg::FUNC_FREE &&
                            npca_pkg::node_valid(req_word.chain_head)) begin
                  state_in = npca_pkg::ST_FWALK;
               end
            end
         end
         npca_pkg::ST_PWALK: begin
            if (walk_dec == 10'd0 || !npca_pkg::node_valid(rd_data)) begin
               state_in = npca_pkg::ST_CREAD;
            end
         end
         npca_pkg::ST_CREAD: state_in = npca_pkg::ST_DONE;
         npca_pkg::ST_FWALK: begin
            if (!(npca_pkg::node_valid(rd_data) && walk_cnt_ff < 10'(npca_pkg::POOL_NODES))) begin
               state_in = npca_pkg::ST_DONE;
            end
         end
         npca_pkg::ST_DONE: begin
            if (load_rsp) state_in = npca_pkg::ST_IDLE;
         end
         default: state_in = npca_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      free_head_in    = free_head_ff;
      avail_in        = avail_ff;
      run_rem_in      = run_rem_ff;
      run_first_in    = run_first_ff;
      run_cursor_in   = run_cursor_ff;
      run_prev_in     = run_prev_ff;
      walk_ptr_in     = walk_ptr_ff;
      walk_cnt_in     = walk_cnt_ff;
      chain_head_in   = chain_head_ff;
      clr_idx_in      = clr_idx_ff;
      clr_init_in     = clr_init_ff;
      res_in          = res_ff;
      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = walk_ptr_ff[AW-1:0];
      ram_ctl.wr_data = free_head_ff;
      ram_ctl.rd_addr = run_cursor_ff[AW-1:0];
      cur_next        = run_cursor_ff;
      prev_next       = run_prev_ff;
      unique case (state_ff)
         // rewrite links in ascending order, last entry null
         npca_pkg::ST_CLEAR: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = clr_idx_ff;
            ram_ctl.wr_data = NW'(clr_idx_ff) + NW'(1);
            clr_idx_in      = clr_idx_ff + AW'(1);
         end
         npca_pkg::ST_IDLE: begin
            if (accept) begin
               res_in.status       = npca_pkg::STAT_DONE;
               res_in.node_index   = npca_pkg::NULL_NODE;
               res_in.parent_index = npca_pkg::NULL_NODE;
               res_in.freed_count  = 10'd0;
               res_in.rest         = 16'sd0;
               res_in.last_of_run  = 1'b0;
               if (req_word.func == npca_pkg::FUNC_INIT) begin
                  clr_idx_in    = '0;
                  clr_init_in   = 1'b1;
                  free_head_in  = '0;
                  avail_in      = 16'(npca_pkg::POOL_NODES);
                  run_rem_in    = 10'd0;
                  run_first_in  = npca_pkg::NULL_NODE;
                  run_cursor_in = npca_pkg::NULL_NODE;
                  run_prev_in   = npca_pkg::NULL_NODE;
               end else if (req_word.func == npca_pkg::FUNC_GET_NODE) begin
                  if (!in_run) begin
                     res_in.status = npca_pkg::STAT_IGNORED;
                  end else if (req_word.hier_byte != npca_pkg::NO_PARENT_BYTE &&
                               npca_pkg::node_valid(run_first_ff)) begin
                     if (req_word.hier_byte == 8'd0) begin
                        res_in.parent_index = run_first_ff;
                     end else begin
                        walk_ptr_in     = run_first_ff;
                        walk_cnt_in     = {2'd0, req_word.hier_byte};
                        ram_ctl.rd_addr = run_first_ff[AW-1:0];
                     end
                  end
               end else if (in_run || req_word.func > npca_pkg::FUNC_INIT) begin
                  res_in.status = npca_pkg::STAT_IGNORED;
               end else begin
                  priority case (req_word.func)
                     npca_pkg::FUNC_GET_START: begin
                        if (req_word.count == 10'd0 || avail_wide < cnt_wide) begin
                           res_in.status = npca_pkg::STAT_REFUSED;
                        end else begin
                           avail_in          = 16'(avail_wide - cnt_wide);
                           run_rem_in        = req_word.count;
                           run_first_in      = free_head_ff;
                           run_cursor_in     = free_head_ff;
                           run_prev_in       = npca_pkg::NULL_NODE;
                           res_in.node_index = free_head_ff;
                        end
                     end
                     npca_pkg::FUNC_FREE: begin
                        walk_ptr_in     = req_word.chain_head;
                        walk_cnt_in     = 10'd1;
                        chain_head_in   = req_word.chain_head;
                        ram_ctl.rd_addr = req_word.chain_head[AW-1:0];
                     end
                     npca_pkg::FUNC_SUB: avail_in = npca_pkg::sat16(avail_wide - cnt_wide);
                     default:            avail_in = npca_pkg::sat16(avail_wide + cnt_wide);
                  endcase
               end
            end
         end
         // one parent link per cycle; read data follows the previous address
         npca_pkg::ST_PWALK: begin
            if (walk_dec == 10'd0 || !npca_pkg::node_valid(rd_data)) begin
               res_in.parent_index = npca_pkg::node_valid(rd_data) ? rd_data
                                                                   : npca_pkg::NULL_NODE;
               ram_ctl.rd_addr = run_cursor_ff[AW-1:0];
            end else begin
               walk_ptr_in     = rd_data;
               walk_cnt_in     = walk_dec;
               ram_ctl.rd_addr = rd_data[AW-1:0];
            end
         end
         // hand out the cursor node and advance; cut the run at its end
         npca_pkg::ST_CREAD: begin
            if (npca_pkg::node_valid(run_cursor_ff)) begin
               res_in.node_index = run_cursor_ff;
               prev_next         = run_cursor_ff;
               cur_next          = rd_data;
            end else begin
               res_in.parent_index = npca_pkg::NULL_NODE;
            end
            run_prev_in   = prev_next;
            run_cursor_in = cur_next;
            run_rem_in    = rem_dec;
            if (rem_dec == 10'd0) begin
               res_in.last_of_run = 1'b1;
               free_head_in       = cur_next;
               if (npca_pkg::node_valid(prev_next)) begin
                  ram_ctl.wr_en   = 1'b1;
                  ram_ctl.wr_addr = prev_next[AW-1:0];
                  ram_ctl.wr_data = npca_pkg::NULL_NODE;
               end
            end
         end
         // walk the freed chain to its tail, then splice onto the free list
         npca_pkg::ST_FWALK: begin
            if (npca_pkg::node_valid(rd_data) && walk_cnt_ff < 10'(npca_pkg::POOL_NODES)) begin
               walk_ptr_in     = rd_data;
               walk_cnt_in     = walk_cnt_ff + 10'd1;
               ram_ctl.rd_addr = rd_data[AW-1:0];
            end else begin
               ram_ctl.wr_en      = 1'b1;
               ram_ctl.wr_addr    = walk_ptr_ff[AW-1:0];
               ram_ctl.wr_data    = free_head_ff;
               free_head_in       = chain_head_ff;
               res_in.freed_count = walk_cnt_ff;
               avail_in = npca_pkg::sat16(avail_wide + $signed({7'd0, walk_cnt_ff}));
            end
         end
         npca_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_in       = res_ff;
         rsp_in.rest  = avail_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= npca_pkg::ST_CLEAR;
         free_head_ff  <= '0;
         avail_ff      <= 16'(npca_pkg::POOL_NODES);
         run_rem_ff    <= 10'd0;
         run_first_ff  <= npca_pkg::NULL_NODE;
         run_cursor_ff <= npca_pkg::NULL_NODE;
         run_prev_ff   <= npca_pkg::NULL_NODE;
         clr_idx_ff    <= '0;
         clr_init_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         avail_ff      <= avail_in;
         run_rem_ff    <= run_rem_in;
         run_first_ff  <= run_first_in;
         run_cursor_ff <= run_cursor_in;
         run_prev_ff   <= run_prev_in;
         clr_idx_ff    <= clr_idx_in;
         clr_init_ff   <= clr_init_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ptr_ff   <= walk_ptr_in;
      walk_cnt_ff   <= walk_cnt_in;
      chain_head_ff <= chain_head_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### design/npca_checker.sv
// npca_checker: port-level assertions for node_pool_chain_allocator
// depends on npca_pkg; bound to the top level below
module npca_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input npca_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input npca_pkg::rsp_type rsp_word
);

   // the clearing pass after reset holds off requests and results
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (req_stall && !rsp_valid))
      else $error("activity right after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

   // end of run only on a completed get node
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last_of_run) |-> (rsp_word.status == npca_pkg::STAT_DONE))
      else $error("last_of_run on a refused or ignored word");

   // refused or ignored words free nothing
   a_fail_nofree: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status != npca_pkg::STAT_DONE) |-> (rsp_word.freed_count == 10'd0))
      else $error("freed count on a failed word");

endmodule

bind node_pool_chain_allocator npca_checker u_npca_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### tb/testbench.sv
// testbench for node_pool_chain_allocator: random and directed request words,
// results checked against an in-bench pool model; depends on npca_pkg and the block
`timescale 1ns / 1ps

class pool_scoreboard;
   logic [9:0]  links [512];
   logic [9:0]  parents [512];
   logic [9:0]  free_head;
   int          avail;
   int          run_left;
   logic [9:0]  run_first, run_cursor, run_prev;
   npca_pkg::rsp_type expected_rsps[$];
   int          mismatches;

   function void pool_clear();
      for (int i = 0; i < 512; i++) begin
         links[i] = 10'(i + 1);
         parents[i] = npca_pkg::NULL_NODE;
      end
      links[511] = npca_pkg::NULL_NODE;
      free_head = 0;
      avail = 512;
      run_left = 0;
      run_first = npca_pkg::NULL_NODE;
      run_cursor = npca_pkg::NULL_NODE;
      run_prev = npca_pkg::NULL_NODE;
   endfunction

   function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // apply one accepted request word and queue its expected result
   function void note_request(npca_pkg::req_type w);
      npca_pkg::rsp_type r;
      logic [9:0] p, t;
      int c;
      bit in_run;
      in_run = run_left != 0;
      r = '0;
      r.node_index = npca_pkg::NULL_NODE;
      r.parent_index = npca_pkg::NULL_NODE;
      r.status = npca_pkg::STAT_DONE;
      if (w.func == npca_pkg::FUNC_INIT) begin
         pool_clear();
      end else if (w.func == npca_pkg::FUNC_GET_NODE) begin
         if (!in_run) begin
            r.status = npca_pkg::STAT_IGNORED;
         end else begin
            if (w.hier_byte != npca_pkg::NO_PARENT_BYTE && run_first < 512) begin
               p = run_first;
               for (int j = w.hier_byte; j > 0 && p < 512; j--) p = links[p];
               r.parent_index = (p < 512) ? p : npca_pkg::NULL_NODE;
            end
            if (run_cursor < 512) begin
               r.node_index = run_cursor;
               parents[run_cursor] = r.parent_index;
               run_prev = run_cursor;
               run_cursor = links[run_cursor];
            end else begin
               r.parent_index = npca_pkg::NULL_NODE;
            end
            run_left--;
            if (run_left == 0) begin
               r.last_of_run = 1'b1;
               if (run_prev < 512) begin
                  free_head = links[run_prev];
                  links[run_prev] = npca_pkg::NULL_NODE;
               end
            end
         end
      end else if (in_run || w.func > npca_pkg::FUNC_INIT) begin
         r.status = npca_pkg::STAT_IGNORED;
      end else if (w.func == npca_pkg::FUNC_GET_START) begin
         if (w.count == 0 || avail < int'(w.count)) begin
            r.status = npca_pkg::STAT_REFUSED;
         end else begin
            avail -= w.count;
            run_left = w.count;
            run_first = free_head;
            run_cursor = free_head;
            run_prev = npca_pkg::NULL_NODE;
            r.node_index = free_head;
         end
      end else if (w.func == npca_pkg::FUNC_FREE) begin
         if (w.chain_head < 512) begin
            t = w.chain_head;
            c = 1;
            while (links[t] < 512 && c < 512) begin
               t = links[t];
               c++;
            end
            links[t] = free_head;
            free_head = w.chain_head;
            r.freed_count = 10'(c);
            avail = clamp16(avail + c);
         end
      end else if (w.func == npca_pkg::FUNC_SUB) begin
         avail = clamp16(avail - int'(w.count));
      end else begin
         avail = clamp16(avail + int'(w.count));
      end
      r.rest = 16'(avail);
      expected_rsps.push_back(r);
   endfunction

   // compare one accepted result word with the oldest expectation
   function void check_result(npca_pkg::rsp_type got);
      npca_pkg::rsp_type want;
      if (expected_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %h", got);
         return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status || got.node_index !== want.node_index ||
          got.parent_index !== want.parent_index ||
          got.freed_count !== want.freed_count || got.rest !== want.rest ||
          got.last_of_run !== want.last_of_run) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected st %0d node %0d par %0d freed %0d rest %0d",
                      " last %0d, got st %0d node %0d par %0d freed %0d rest %0d last %0d"},
               want.status, want.node_index, want.parent_index, want.freed_count,
               want.rest, want.last_of_run, got.status, got.node_index,
               got.parent_index, got.freed_count, got.rest, got.last_of_run);
      end
   endfunction
endclass

module testbench;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   npca_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_stall;
   npca_pkg::rsp_type rsp_word;
   logic              csr_unused;

   pool_scoreboard pool;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_cycles;
   int      cycle_count;
   logic [9:0] granted [$];

   node_pool_chain_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_unused (csr_unused)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // timeout guard
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver: random stall, long hold-offs on request, checks accepted words
   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            pool.check_result(rsp_word);
            if (rsp_word.status == npca_pkg::STAT_DONE &&
                rsp_word.node_index < npca_pkg::NULL_NODE &&
                rsp_word.freed_count == 0 && rsp_word.parent_index <= npca_pkg::NULL_NODE)
               granted.push_back(rsp_word.node_index);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // offer one word and wait until it is taken; valid drops on the next idle
   task automatic send_word(npca_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      pool.note_request(w);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_op(logic [2:0] f, logic [9:0] n, logic [7:0] h, logic [9:0] hd);
      npca_pkg::req_type w;
      w.func = f;
      w.count = n;
      w.hier_byte = h;
      w.chain_head = hd;
      send_word(w);
   endtask

   // get start followed by its node words, mostly well formed
   task automatic send_get_run(int n);
      int avail_now;
      avail_now = pool.avail;
      send_op(npca_pkg::FUNC_GET_START, 10'(n), 8'($urandom), 10'($urandom));
      if (n != 0 && n <= avail_now)
         for (int i = 0; i < n; i++)
            send_op(npca_pkg::FUNC_GET_NODE, 10'($urandom),
                    ($urandom_range(3) == 0) ? npca_pkg::NO_PARENT_BYTE
                                             : 8'($urandom_range(i + 2)),
                    10'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pool.expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int items);
      int k;
      int sent;
      logic [9:0] hd;
      sent = 0;
      while (sent < items) begin
         k = $urandom_range(99);
         if (k < 45) begin
            int n;
            n = ($urandom_range(20) == 0) ? $urandom_range(512) : $urandom_range(1, 6);
            send_get_run(n);
            sent += n + 1;
         end else if (k < 65) begin
            // free a chain head from a past grant, or any index
            if (granted.size() != 0 && $urandom_range(3) != 0) begin
               hd = granted[$urandom_range(granted.size() - 1)];
               granted.delete();
            end else begin
               hd = 10'($urandom);
            end
            send_op(npca_pkg::FUNC_FREE, 10'($urandom), 8'($urandom), hd);
            sent++;
         end else if (k < 75) begin
            send_op(($urandom_range(1) != 0) ? npca_pkg::FUNC_ADD : npca_pkg::FUNC_SUB,
                    10'($urandom_range(40)), 8'($urandom), 10'($urandom));
            sent++;
         end else if (k < 78) begin
            send_op(npca_pkg::FUNC_INIT, 10'($urandom), 8'($urandom), 10'($urandom));
            granted.delete();
            sent++;
         end else begin
            send_op(3'($urandom), 10'($urandom), 8'($urandom), 10'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      pool = new();
      pool.pool_clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every func, mode rules, saturation
      send_op(npca_pkg::FUNC_GET_NODE, 10'h3ff, 8'hff, 10'h3ff);
      send_op(npca_pkg::FUNC_GET_START, 10'd0, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_GET_START, 10'd513, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_GET_START, 10'd3, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_ADD, 10'd5, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_GET_NODE, 10'd0, 8'hff, 10'h000);
      send_op(npca_pkg::FUNC_GET_NODE, 10'd0, 8'h01, 10'h000);
      send_op(npca_pkg::FUNC_GET_NODE, 10'd0, 8'hfe, 10'h000);
      send_op(npca_pkg::FUNC_FREE, 10'd0, 8'h00, 10'd0);
      send_op(npca_pkg::FUNC_FREE, 10'd0, 8'h00, npca_pkg::NULL_NODE);
      send_op(3'd6, 10'd0, 8'h00, 10'h000);
      send_op(3'd7, 10'h3ff, 8'hff, 10'h3ff);
      send_op(npca_pkg::FUNC_SUB, 10'd512, 8'h00, 10'h000);
      for (int i = 0; i < 70; i++) send_op(npca_pkg::FUNC_SUB, 10'h3ff, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_GET_START, 10'd1, 8'h00, 10'h000);
      for (int i = 0; i < 40; i++) send_op(npca_pkg::FUNC_ADD, 10'h3ff, 8'h00, 10'h000);
      // promise every node of the list while the counter is far above it
      send_op(npca_pkg::FUNC_GET_START, 10'd512, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_INIT, 10'd0, 8'h00, 10'h000);
      send_op(npca_pkg::FUNC_ADD, 10'd4, 8'h00, 10'h000);
      send_get_run(3);
      send_get_run(2);
      send_op(npca_pkg::FUNC_FREE, 10'd0, 8'h00, 10'd0);
      // cyclic chain: free a node already on the list
      send_op(npca_pkg::FUNC_FREE, 10'd0, 8'h00, 10'd100);
      send_op(npca_pkg::FUNC_INIT, 10'd0, 8'h00, 10'h000);
      wait_drained();

      send_idle_pct = 13;
      recv_idle_pct = 88;
      random_phase(350);
      // long receiver hold-off while the sender keeps offering
      hold_cycles = 400;
      random_phase(100);
      send_idle_pct = 88;
      recv_idle_pct = 13;
      random_phase(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(400);

      wait_drained();
      repeat (600) @(posedge clock);
      if (pool.mismatches == 0 && pool.expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
